/* design/cfr_pkg.sv */
// ----------------------------------------------------------------------------
// cfr_pkg: shared types and constants of the command frame receiver
//
// Holds the result codes, the frame marker bytes and the event record that
// the parser hands to the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

    // Largest payload that the hardware buffer can hold.
    localparam int MAX_PAYLOAD_DEF = 48;

    // Reset value of the idle gap register.
    localparam logic [7:0] GAP_TICKS_RST = 8'd5;

    // Request types on the input channel.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Frame marker bytes.
    localparam logic [7:0] BYTE_SOF     = 8'hFF;
    localparam logic [7:0] TYPE_ACK_REQ = 8'hAA;
    localparam logic [7:0] TYPE_NO_ACK  = 8'hBB;
    localparam logic [7:0] TYPE_REPLY   = 8'h55;

    // Reply codes that the block asks to be sent.
    localparam logic [7:0] CODE_NAK = 8'h7F;
    localparam logic [7:0] CODE_ACK = 8'h01;

    // Drop reasons.
    localparam logic [7:0] DROP_HEADER = 8'd0;
    localparam logic [7:0] DROP_LENGTH = 8'd1;
    localparam logic [7:0] DROP_GAP    = 8'd2;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_REPLY   = 3'd0,
        KIND_HEADER  = 3'd1,
        KIND_PAYLOAD = 3'd2,
        KIND_ACK     = 3'd3,
        KIND_DROP    = 3'd4
    } res_kind_t;

    // What one accepted request leads to.
    typedef struct packed {
        logic       single;    // exactly one result, given by kind and value
        logic       good;      // good frame: header and payload follow
        logic       ack_want;  // good frame that asks for an 01 reply first
        res_kind_t  kind;
        logic [7:0] command;
        logic [7:0] value;
        logic [5:0] len;
    } cfr_event_t;

endpackage

`default_nettype wire

/* design/cfr_payload_buf.sv */
// ----------------------------------------------------------------------------
// cfr_payload_buf: payload byte buffer
//
// One write port for the parser and one registered read port for the replay
// of a finished frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_payload_buf #(
    parameter int DEPTH = 48,
    parameter int AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/cfr_parser.sv */
// ----------------------------------------------------------------------------
// cfr_parser: frame parser and idle gap timer
//
// Steps the frame parser by one received byte or one tick, keeps the running
// checksum and the gap counter, stores payload bytes and reports what the
// request leads to.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_parser
    import cfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int AW          = 6
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [7:0]    cfg_wdata,
    input  wire logic          accept,
    input  wire logic          req_type,
    input  wire logic [7:0]    rx_byte,
    output cfr_event_t         ev,
    output logic               wr_en,
    output logic      [AW-1:0] wr_addr,
    output logic      [7:0]    wr_data
);

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_TYPE,
        PH_CMD,
        PH_LEN,
        PH_DATA,
        PH_CHK,
        PH_CODE
    } phase_t;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    phase_t     phase_reg,   phase_next;
    logic [1:0] fkind_reg,   fkind_next;
    logic [7:0] fcmd_reg,    fcmd_next;
    logic [5:0] flen_reg,    flen_next;
    logic [5:0] seen_reg,    seen_next;
    logic [7:0] xor_reg,     xor_next;
    logic [7:0] idle_reg,    idle_next;
    logic       discard_reg, discard_next;
    logic [7:0] gap_reg;
    logic [5:0] seen_inc;

    assign seen_inc = seen_reg + 6'd1;

    // Payload bytes go to the buffer at the current fill position.
    assign wr_addr = seen_reg[AW-1:0];
    assign wr_data = rx_byte;

    // Next parser state and the result that this request leads to.
    always_comb
    begin
        phase_next   = phase_reg;
        fkind_next   = fkind_reg;
        fcmd_next    = fcmd_reg;
        flen_next    = flen_reg;
        seen_next    = seen_reg;
        xor_next     = xor_reg;
        idle_next    = idle_reg;
        discard_next = discard_reg;
        wr_en        = 1'b0;
        ev           = '0;
        ev.kind      = KIND_DROP;
        ev.command   = fcmd_reg;
        ev.len       = flen_reg;

        if (accept && req_type == REQ_BYTE)
        begin
            idle_next = 8'd1;
            if (!discard_reg)
            begin
                case (phase_reg)
                    PH_WAIT:
                    begin
                        fcmd_next  = 8'd0;
                        flen_next  = 6'd0;
                        seen_next  = 6'd0;
                        xor_next   = 8'd0;
                        fkind_next = 2'd0;
                        ev.command = 8'd0;
                        if (rx_byte == BYTE_SOF)
                        begin
                            phase_next = PH_TYPE;
                        end
                        else
                        begin
                            ev.single    = 1'b1;
                            ev.value     = DROP_HEADER;
                            discard_next = 1'b1;
                        end
                    end
                    PH_TYPE:
                    begin
                        if (rx_byte == TYPE_ACK_REQ)
                        begin
                            fkind_next = 2'd0;
                            phase_next = PH_CMD;
                        end
                        else if (rx_byte == TYPE_NO_ACK)
                        begin
                            fkind_next = 2'd1;
                            phase_next = PH_CMD;
                        end
                        else if (rx_byte == TYPE_REPLY)
                        begin
                            fkind_next = 2'd2;
                            phase_next = PH_CMD;
                        end
                        else
                        begin
                            ev.single    = 1'b1;
                            ev.value     = DROP_HEADER;
                            phase_next   = PH_WAIT;
                            discard_next = 1'b1;
                        end
                    end
                    PH_CMD:
                    begin
                        fcmd_next  = rx_byte;
                        xor_next   = rx_byte;
                        phase_next = (fkind_reg == 2'd2) ? PH_CODE : PH_LEN;
                    end
                    PH_CODE:
                    begin
                        ev.single  = 1'b1;
                        ev.kind    = KIND_ACK;
                        ev.value   = rx_byte;
                        phase_next = PH_WAIT;
                    end
                    PH_LEN:
                    begin
                        if (rx_byte > MAX_LEN)
                        begin
                            ev.single    = 1'b1;
                            ev.value     = DROP_LENGTH;
                            phase_next   = PH_WAIT;
                            discard_next = 1'b1;
                        end
                        else
                        begin
                            flen_next  = rx_byte[5:0];
                            xor_next   = xor_reg ^ rx_byte;
                            seen_next  = 6'd0;
                            phase_next = (rx_byte == 8'd0) ? PH_CHK : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        wr_en     = 1'b1;
                        xor_next  = xor_reg ^ rx_byte;
                        seen_next = seen_inc;
                        if (seen_inc >= flen_reg)
                        begin
                            phase_next = PH_CHK;
                        end
                    end
                    PH_CHK:
                    begin
                        phase_next = PH_WAIT;
                        if (rx_byte != xor_reg)
                        begin
                            ev.single = 1'b1;
                            ev.kind   = KIND_REPLY;
                            ev.value  = CODE_NAK;
                        end
                        else
                        begin
                            ev.good     = 1'b1;
                            ev.ack_want = (fkind_reg == 2'd0);
                        end
                    end
                    default:
                    begin
                        phase_next = PH_WAIT;
                    end
                endcase
            end
        end
        else if (accept && idle_reg != 8'd0)
        begin
            // Tick: count idle time and end the burst at the gap.
            if (idle_reg >= gap_reg)
            begin
                idle_next = 8'd0;
                if (phase_reg != PH_WAIT && !discard_reg)
                begin
                    ev.single = 1'b1;
                    ev.value  = DROP_GAP;
                end
                phase_next   = PH_WAIT;
                discard_next = 1'b0;
            end
            else
            begin
                idle_next = idle_reg + 8'd1;
            end
        end
    end

    // Parser state and gap register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            fkind_reg   <= 2'd0;
            fcmd_reg    <= 8'd0;
            flen_reg    <= 6'd0;
            seen_reg    <= 6'd0;
            xor_reg     <= 8'd0;
            idle_reg    <= 8'd0;
            discard_reg <= 1'b0;
            gap_reg     <= GAP_TICKS_RST;
        end
        else
        begin
            phase_reg   <= phase_next;
            fkind_reg   <= fkind_next;
            fcmd_reg    <= fcmd_next;
            flen_reg    <= flen_next;
            seen_reg    <= seen_next;
            xor_reg     <= xor_next;
            idle_reg    <= idle_next;
            discard_reg <= discard_next;
            if (cfg_we)
            begin
                gap_reg <= cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

/* design/cmd_frame_receiver_with_ack_top.sv */
// ----------------------------------------------------------------------------
// cmd_frame_receiver_with_ack_top: command frame receiver with acknowledge
//
// Usage:
//   Input channel (in_valid/in_ready, req_type, rx_byte) carries one received
//   byte or one 10 ms tick per request. Output channel (out_valid/out_ready)
//   carries results: kind, command, value, payload_len and last, where last
//   marks the final result of one request. cfg_we/cfg_wdata write gap_ticks.
//   A request is taken when in_valid and in_ready are both high. A request
//   with no result frees the input at once, so the next one can follow in the
//   next cycle. A request with results keeps in_ready low while the result
//   sequencer runs: the request is first staged in the sequencer registers,
//   then one result per cycle goes into the output register when the output
//   is not stalled. A good frame replays its buffered payload through the
//   registered read port of the payload buffer, one byte per cycle when the
//   output is not stalled. in_ready rises again while the last result still
//   waits in the output register.
//   When the receiver stalls, the output register holds its result and the
//   sequencer waits. Reset clears the parser, the gap counter and the output
//   register and sets gap_ticks to 5; the payload buffer is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module cmd_frame_receiver_with_ack_top
    import cfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       req_type,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [2:0] kind,
    output logic      [7:0] command,
    output logic      [7:0] value,
    output logic      [5:0] payload_len,
    output logic            last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_REPLY,
        ST_HDR,
        ST_DATA
    } seq_state_t;

    seq_state_t state_reg;
    cfr_event_t ev;
    logic       accept;
    logic       out_free;
    logic       out_load;
    logic       wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0] wr_data;
    logic       rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0] rd_data;
    logic       data_last;

    res_kind_t  pend_kind_reg;
    logic [7:0] pend_value_reg;
    logic [7:0] cmd_reg;
    logic [5:0] len_reg;
    logic [5:0] cnt_reg;
    logic [5:0] cnt_inc;

    logic       out_valid_reg;
    res_kind_t  out_kind_reg;
    logic [7:0] out_cmd_reg;
    logic [7:0] out_value_reg;
    logic [5:0] out_len_reg;
    logic       out_last_reg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cnt_inc   = cnt_reg + 6'd1;
    assign data_last = (cnt_inc == len_reg);

    // The output register takes a new result in every busy sequencer state once it is free.
    assign out_load  = out_free && (state_reg == ST_SINGLE || state_reg == ST_REPLY ||
                                    state_reg == ST_HDR || state_reg == ST_DATA);

    // Buffer reads: first byte with the header, then one per pushed byte.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (out_free && state_reg == ST_HDR && len_reg != 6'd0)
        begin
            rd_en = 1'b1;
        end
        else if (out_free && state_reg == ST_DATA && !data_last)
        begin
            rd_en   = 1'b1;
            rd_addr = cnt_inc[AW-1:0];
        end
    end

    cfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .req_type  (req_type),
        .rx_byte   (rx_byte),
        .ev        (ev),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    cfr_payload_buf #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            pend_kind_reg  <= KIND_DROP;
            pend_value_reg <= 8'd0;
            cmd_reg        <= 8'd0;
            len_reg        <= 6'd0;
            cnt_reg        <= 6'd0;
            out_kind_reg   <= KIND_DROP;
            out_cmd_reg    <= 8'd0;
            out_value_reg  <= 8'd0;
            out_len_reg    <= 6'd0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        pend_kind_reg  <= ev.kind;
                        pend_value_reg <= ev.value;
                        cmd_reg        <= ev.command;
                        len_reg        <= ev.len;
                        cnt_reg        <= 6'd0;
                        if (ev.single)
                        begin
                            state_reg <= ST_SINGLE;
                        end
                        else if (ev.good)
                        begin
                            state_reg <= ev.ack_want ? ST_REPLY : ST_HDR;
                        end
                    end
                end
                ST_SINGLE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= pend_kind_reg;
                        out_cmd_reg   <= cmd_reg;
                        out_value_reg <= pend_value_reg;
                        out_len_reg   <= 6'd0;
                        out_last_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_REPLY:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= KIND_REPLY;
                        out_cmd_reg   <= cmd_reg;
                        out_value_reg <= CODE_ACK;
                        out_len_reg   <= 6'd0;
                        out_last_reg  <= 1'b0;
                        state_reg     <= ST_HDR;
                    end
                end
                ST_HDR:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= KIND_HEADER;
                        out_cmd_reg   <= cmd_reg;
                        out_value_reg <= 8'd0;
                        out_len_reg   <= len_reg;
                        out_last_reg  <= (len_reg == 6'd0);
                        state_reg     <= (len_reg == 6'd0) ? ST_IDLE : ST_DATA;
                    end
                end
                ST_DATA:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= KIND_PAYLOAD;
                        out_cmd_reg   <= cmd_reg;
                        out_value_reg <= rd_data;
                        out_len_reg   <= len_reg;
                        out_last_reg  <= data_last;
                        cnt_reg       <= cnt_inc;
                        if (data_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign command     = out_cmd_reg;
    assign value       = out_value_reg;
    assign payload_len = out_len_reg;
    assign last        = out_last_reg;

    // The replay never runs past the frame length.
    a_replay_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA) |-> (cnt_reg < len_reg))
        else $error("payload replay index beyond frame length");

    // A payload result always belongs to a frame with a payload.
    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_PAYLOAD) |-> (out_len_reg != 6'd0))
        else $error("payload result with zero frame length");

    // An 01 reply that is not final is followed at once by the frame header.
    a_reply_then_header: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && out_kind_reg == KIND_REPLY && !out_last_reg)
        |=> (out_valid_reg && out_kind_reg == KIND_HEADER))
        else $error("ack reply not followed by frame header");

endmodule

`default_nettype wire
